>>> rtl/u8d_pkg.sv
package u8d_pkg;

    typedef enum logic [0:0] {
        OP_PUSH  = 1'b0,
        OP_FLUSH = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode     opcode;
        logic [7:0]  data_byte;
    } t_in_req;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last;
    } t_out_req;

    // Code units owed for one request: up to two distinct units, the rest repeat unit1.
    typedef struct packed {
        logic [2:0]  count;
        logic [15:0] unit0;
        logic [15:0] unit1;
    } t_pack;

    localparam int unsigned CpWidth = 21;

    localparam logic [15:0] QMARK     = 16'h003F;
    localparam logic [15:0] REPL      = 16'hFFFD;
    localparam logic [15:0] HI_SURR   = 16'hD800;
    localparam logic [15:0] LO_SURR   = 16'hDC00;
    localparam logic [7:0]  CONT_MASK = 8'hC0;
    localparam logic [7:0]  CONT_TAG  = 8'h80;

endpackage

>>> rtl/u8d_decode.sv
module u8d_decode
    import u8d_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_in_req i_req,
    output t_pack   o_pack
);

    logic [2:0]         r_remaining, n_remaining;
    logic [2:0]         r_held, n_held;
    logic [2:0]         r_length, n_length;
    logic [CpWidth-1:0] r_accum, n_accum;

    logic [7:0]         b;
    logic               is_cont;
    logic [2:0]         conts;
    logic [CpWidth-1:0] lead_bits;
    logic [CpWidth-1:0] cp;
    logic [CpWidth-1:0] v;
    logic               valid_seq;

    assign b       = i_req.data_byte;
    assign is_cont = (b & CONT_MASK) == CONT_TAG;
    assign cp      = {r_accum[CpWidth-7:0], b[5:0]};
    assign v       = cp - CpWidth'(21'h10000);

    always_comb begin
        casez (b[5:0])
            6'b0?????: conts = 3'd1;
            6'b10????: conts = 3'd2;
            6'b110???: conts = 3'd3;
            6'b1110??: conts = 3'd4;
            6'b11110?: conts = 3'd5;
            6'b111110: conts = 3'd6;
            default:   conts = 3'd7;
        endcase
    end

    always_comb begin
        case (conts)
            3'd1:    lead_bits = CpWidth'(b[4:0]);
            3'd2:    lead_bits = CpWidth'(b[3:0]);
            3'd3:    lead_bits = CpWidth'(b[2:0]);
            3'd4:    lead_bits = CpWidth'(b[1:0]);
            3'd5:    lead_bits = CpWidth'(b[0]);
            default: lead_bits = '0;
        endcase
    end

    always_comb begin
        case (r_length)
            3'd1:    valid_seq = cp >= CpWidth'(21'h80);
            3'd2:    valid_seq = (cp >= CpWidth'(21'h800))
                                 && ((cp < CpWidth'(21'hD800)) || (cp > CpWidth'(21'hDFFF)));
            3'd3:    valid_seq = (cp >= CpWidth'(21'h10000)) && (cp <= CpWidth'(21'h10FFFF));
            default: valid_seq = 1'b0;
        endcase
    end

    always_comb begin
        n_remaining = r_remaining;
        n_held      = r_held;
        n_length    = r_length;
        n_accum     = r_accum;
        o_pack      = '{count: 3'd0, unit0: QMARK, unit1: QMARK};
        unique case (i_req.opcode)
            OP_FLUSH: begin
                o_pack.count = r_held;
                n_remaining  = '0;
                n_held       = '0;
                n_length     = '0;
                n_accum      = '0;
            end
            OP_PUSH: begin
                if (r_remaining == 3'd0) begin
                    if (is_cont) begin
                        o_pack.count = 3'd1;
                    end else if (!b[7]) begin
                        o_pack.count = 3'd1;
                        o_pack.unit0 = {8'h00, b};
                    end else begin
                        // open a sequence
                        n_remaining = conts;
                        n_length    = conts;
                        n_held      = 3'd1;
                        n_accum     = lead_bits;
                    end
                end else if (!is_cont) begin
                    // drop the byte, mark every byte held
                    o_pack.count = r_held;
                    n_remaining  = '0;
                    n_held       = '0;
                    n_length     = '0;
                    n_accum      = '0;
                end else if (r_remaining != 3'd1) begin
                    n_accum     = cp;
                    n_held      = r_held + 3'd1;
                    n_remaining = r_remaining - 3'd1;
                end else begin
                    n_remaining = '0;
                    n_held      = '0;
                    n_length    = '0;
                    n_accum     = '0;
                    if (!valid_seq) begin
                        o_pack.count = 3'd1;
                        o_pack.unit0 = REPL;
                    end else if (cp >= CpWidth'(21'h10000)) begin
                        o_pack.count = 3'd2;
                        o_pack.unit0 = HI_SURR | {6'd0, v[19:10]};
                        o_pack.unit1 = LO_SURR | {6'd0, v[9:0]};
                    end else begin
                        o_pack.count = 3'd1;
                        o_pack.unit0 = cp[15:0];
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_held      <= '0;
            r_length    <= '0;
            r_accum     <= '0;
        end else if (i_accept) begin
            r_remaining <= n_remaining;
            r_held      <= n_held;
            r_length    <= n_length;
            r_accum     <= n_accum;
        end
    end

endmodule

>>> rtl/u8d_emit.sv
module u8d_emit
    import u8d_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_pack    i_pack,
    input  logic     i_out_stall,
    output logic     o_free,
    output logic     o_out_valid,
    output t_out_req o_out_req
);

    logic [2:0]  r_count;
    logic [15:0] r_unit0;
    logic [15:0] r_unit1;
    logic        take;

    assign take                = (r_count != 3'd0) && !i_out_stall;
    assign o_free              = (r_count == 3'd0) || ((r_count == 3'd1) && !i_out_stall);
    assign o_out_valid         = r_count != 3'd0;
    assign o_out_req.code_unit = r_unit0;
    assign o_out_req.last      = r_count == 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_load) begin
            r_count <= i_pack.count;
        end else if (take) begin
            r_count <= r_count - 3'd1;
        end
    end

    // advance: unit1 repeats once the distinct units are gone
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_unit0 <= i_pack.unit0;
            r_unit1 <= i_pack.unit1;
        end else if (take) begin
            r_unit0 <= r_unit1;
        end
    end

endmodule

>>> rtl/utf8_to_utf16_stream_decoder.sv
// UTF-8 byte stream to UTF-16 code unit decoder.
// Input channel: i_in_valid / o_in_stall carry one request per unstalled cycle,
// either a data byte to push or a flush of the pending partial sequence.
// Output channel: o_out_valid / i_out_stall carry one code unit per unstalled
// cycle; last marks the final unit caused by a request. Requests that only open
// or extend a sequence produce no output.
// Latency: the first unit of a request is valid the cycle after it is accepted.
// Throughput: one request per unstalled cycle if each yields at most one unit.
// A request yielding N units (surrogate pair, or up to seven '?' marks from a
// broken sequence or a flush) stalls the input after it is accepted until the
// single output register hands out its last unit, one unit per unstalled cycle.
// Reset (synchronous, active low) returns the decoder to idle with no pending
// sequence and empties the output register.
// When the receiver stalls, the current unit holds; the input stalls as soon
// as the output register cannot take the next request's units.
module utf8_to_utf16_stream_decoder
    import u8d_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    logic  free;
    logic  accept;
    t_pack pack;

    assign o_in_stall = !free;
    assign accept     = i_in_valid && free;

    u8d_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_in_req),
        .o_pack   (pack)
    );

    u8d_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_pack      (pack),
        .i_out_stall (i_out_stall),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req)
    );

endmodule
